FILE: hdl/isc_pkg.sv
// shared constants and controller/datapath signal groups for the insertion sorter
package isc_pkg;

  // fixed field widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned CountW   = 12;
  localparam int unsigned CountMax = (1 << CountW) - 1;

  // default store capacity
  localparam int unsigned MaxElems = 64;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // latch a new word, start scan at the top of the store
    logic shift;    // move the probed entry up one slot
    logic commit;   // write the new word at the scan position
    logic set_ovf;  // drop the word, flag overflow
    logic emit_rd;  // read the next entry for output
    logic clear;    // end of run: back to empty
  } isc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;       // no room for another word
    logic pos_zero;   // scan reached the bottom slot
    logic greater;    // probed entry is greater than the new word
    logic emit_last;  // current read is the last stored entry
  } isc_status_t;

endpackage

FILE: hdl/insertion_sort_with_compare_count.sv
// top level of the insertion sorter with comparison count
// A word is taken when start_i is high and busy_o is low. Each word is placed
// into a store kept in ascending order by probing downward from the top, one
// entry at a time through the store's single read and write ports: each entry
// is read and compared, then shifted up if it is greater than the word, so
// busy_o stays high until the word lands in its slot (or until it is dropped
// when the store is full). On a word with is_final_i set, after its insertion
// the n stored words stream out on consecutive cycles, each marked by valid_o
// for one cycle, lowest first, with end_of_run_o on the last; the receiver
// cannot stall the stream and must take each word as it appears. busy_o falls
// right after the last word and the store is then empty again. Every word
// carries the run's comparison count and the overflow flag.
module insertion_sort_with_compare_count #(
  parameter int unsigned MaxElems = isc_pkg::MaxElems
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [isc_pkg::DataW-1:0] value_i,
  input  logic                             is_final_i,
  output logic                             valid_o,
  output logic signed [isc_pkg::DataW-1:0] sorted_value_o,
  output logic [isc_pkg::CountW-1:0]       compare_count_o,
  output logic                             end_of_run_o,
  output logic                             overflowed_o
);
  import isc_pkg::*;

  isc_cmd_t    cmd;
  isc_status_t status;

  // controller
  isc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .is_final_i (is_final_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  // datapath
  isc_dpath #(
    .MaxElems (MaxElems)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .status_o        (status),
    .valid_o         (valid_o),
    .sorted_value_o  (sorted_value_o),
    .compare_count_o (compare_count_o),
    .end_of_run_o    (end_of_run_o),
    .overflowed_o    (overflowed_o)
  );

endmodule

FILE: hdl/isc_ram.sv
// simple dual-port ram, one write port, one read port with registered data
module isc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/isc_ctrl.sv
// controller state machine for the insertion sorter
module isc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                is_final_i,
  input  isc_pkg::isc_status_t status_i,
  output isc_pkg::isc_cmd_t    cmd_o,
  output logic                busy_o
);
  import isc_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;

  logic [2:0] state_d, state_q;
  logic       final_d, final_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    final_d = final_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          final_d    = is_final_i;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (status_i.full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = final_q ? StEmit : StIdle;
        end else if (status_i.pos_zero) begin
          cmd_o.commit = 1'b1;
          state_d      = final_q ? StEmit : StIdle;
        end else begin
          state_d = StCmp;
        end
      end
      StCmp: begin
        if (status_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d     = StScan;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = final_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        cmd_o.emit_rd = 1'b1;
        if (status_i.emit_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        cmd_o.clear = 1'b1;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

FILE: hdl/isc_dpath.sv
// datapath of the insertion sorter: store, scan position, count and output stage
module isc_dpath #(
  parameter int unsigned MaxElems = isc_pkg::MaxElems
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  isc_pkg::isc_cmd_t                 cmd_i,
  input  logic signed [isc_pkg::DataW-1:0]  value_i,
  output isc_pkg::isc_status_t              status_o,
  output logic                              valid_o,
  output logic signed [isc_pkg::DataW-1:0]  sorted_value_o,
  output logic [isc_pkg::CountW-1:0]        compare_count_o,
  output logic                              end_of_run_o,
  output logic                              overflowed_o
);
  import isc_pkg::*;

  localparam int unsigned AW = $clog2(MaxElems);
  localparam int unsigned CW = $clog2(MaxElems + 1);
  localparam int unsigned SW = CountW + 1;

  logic signed [DataW-1:0] key_q;
  logic [CW-1:0]           fill_d, fill_q;
  logic [CW-1:0]           pos_d, pos_q;
  logic [CW-1:0]           shifts_d, shifts_q;
  logic [AW-1:0]           idx_d, idx_q;
  logic [CountW-1:0]       count_d, count_q;
  logic                    ovf_d, ovf_q;
  logic                    valid_d, valid_q;
  logic                    end_d, end_q;

  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [DataW-1:0]        wdata, rdata;
  logic [CW-1:0]           pos_m1;
  logic [SW-1:0]           count_sum;

  // store
  isc_ram #(
    .Width (DataW),
    .Depth (MaxElems)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign pos_m1 = pos_q - CW'(1);

  // memory port selection
  always_comb begin
    we    = cmd_i.shift | cmd_i.commit;
    waddr = pos_q[AW-1:0];
    wdata = cmd_i.shift ? rdata : key_q;
    raddr = cmd_i.emit_rd ? idx_q : pos_m1[AW-1:0];
  end

  // comparison count update with saturation
  always_comb begin
    count_sum = SW'(count_q) + SW'(shifts_q) + SW'(fill_q != '0);
  end

  // status back to the controller
  always_comb begin
    status_o.full      = (fill_q == CW'(MaxElems));
    status_o.pos_zero  = (pos_q == '0);
    status_o.greater   = ($signed(rdata) > key_q);
    status_o.emit_last = (CW'(idx_q) == CW'(fill_q - CW'(1)));
  end

  // control register updates
  always_comb begin
    fill_d   = fill_q;
    pos_d    = pos_q;
    shifts_d = shifts_q;
    idx_d    = idx_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    if (cmd_i.load) begin
      pos_d    = fill_q;
      shifts_d = '0;
    end
    if (cmd_i.shift) begin
      pos_d    = pos_m1;
      shifts_d = shifts_q + CW'(1);
    end
    if (cmd_i.commit) begin
      fill_d  = fill_q + CW'(1);
      count_d = (count_sum > SW'(CountMax)) ? CountW'(CountMax) : count_sum[CountW-1:0];
    end
    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.emit_rd) begin
      idx_d = idx_q + AW'(1);
    end
    if (cmd_i.clear) begin
      fill_d  = '0;
      idx_d   = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  // output strobe is registered alongside the store's registered read data
  always_comb begin
    valid_d = cmd_i.emit_rd;
    end_d   = cmd_i.emit_rd & status_o.emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      pos_q    <= '0;
      shifts_q <= '0;
      idx_q    <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      valid_q  <= 1'b0;
      end_q    <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      pos_q    <= pos_d;
      shifts_q <= shifts_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      valid_q  <= valid_d;
      end_q    <= end_d;
    end
  end

  // new word latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= value_i;
    end
  end

  assign valid_o         = valid_q;
  assign sorted_value_o  = $signed(rdata);
  assign compare_count_o = count_q;
  assign end_of_run_o    = end_q;
  assign overflowed_o    = ovf_q;

endmodule

FILE: verif/insertion_sort_with_compare_count_tb.sv
// testbench for the insertion sorter: stable ascending order, comparison count and overflow
`timescale 1ns / 100ps

module insertion_sort_with_compare_count_tb;
  import isc_pkg::*;

  localparam int unsigned Cap      = isc_pkg::MaxElems;
  localparam int unsigned IdleMax  = 4000;
  localparam int unsigned TailCyc  = 2 * Cap + 8;

  // one word offered to the sorter
  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
    bit                      steady;  // no random gap in front of this word
  } sort_word_t;

  // one sorted word expected back
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [CountW-1:0]       count;
    logic                    eor;
    logic                    ovf;
  } sorted_word_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic signed [DataW-1:0] value_i;
  logic                    is_final_i;
  logic                    valid_o;
  logic signed [DataW-1:0] sorted_value_o;
  logic [CountW-1:0]       compare_count_o;
  logic                    end_of_run_o;
  logic                    overflowed_o;

  sort_word_t   pending_q[$];
  sorted_word_t sorted_q[$];
  sort_word_t   drv_word;
  sorted_word_t want;
  logic         took_word;

  // shadow of the sorter's store and run state
  logic signed [DataW-1:0] shadow_store [Cap];
  int unsigned             shadow_fill;
  int unsigned             shadow_total;
  bit                      shadow_ovf;

  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned runs_seen;
  int unsigned ovf_runs;
  int unsigned sorted_checked;
  int unsigned peak_count;
  int unsigned mismatches;
  int unsigned idle_cycles;

  insertion_sort_with_compare_count i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .value_i        (value_i),
    .is_final_i     (is_final_i),
    .valid_o        (valid_o),
    .sorted_value_o (sorted_value_o),
    .compare_count_o(compare_count_o),
    .end_of_run_o   (end_of_run_o),
    .overflowed_o   (overflowed_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // insert a word into the shadow store; on the last word of a run queue the sorted words
  task automatic insert_word(input logic signed [DataW-1:0] v, input logic last);
    int unsigned pos;
    int unsigned shifts;
    int unsigned sum;
    if (shadow_fill >= Cap) begin
      shadow_ovf = 1'b1;
    end else begin
      pos    = shadow_fill;
      shifts = 0;
      // equal words stay in front of the new one
      while (pos > 0 && shadow_store[pos-1] > v) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
        shifts++;
      end
      shadow_store[pos] = v;
      if (shadow_fill > 0) begin
        sum          = shadow_total + 1 + shifts;
        shadow_total = (sum > CountMax) ? CountMax : sum;
      end
      shadow_fill++;
    end
    if (last) begin
      for (int unsigned i = 0; i < shadow_fill; i++) begin
        sorted_q.push_back('{value: shadow_store[i], count: shadow_total[CountW-1:0],
                             eor: (i + 1 == shadow_fill), ovf: shadow_ovf});
      end
      runs_seen++;
      if (shadow_ovf) ovf_runs++;
      shadow_fill  = 0;
      shadow_total = 0;
      shadow_ovf   = 1'b0;
    end
  endtask

  // driver: next word goes out on the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || took_word) begin
        if (pending_q.size() != 0 && (pending_q[0].steady || $urandom_range(99) >= 13)) begin
          drv_word = pending_q.pop_front();
          start_i    <= 1'b1;
          value_i    <= drv_word.value;
          is_final_i <= drv_word.last;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on every taken word, check every sorted word
  always @(posedge clk_i) begin
    took_word <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        insert_word(value_i, is_final_i);
        words_taken++;
      end
      if (valid_o) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected sorted word: value %0d count %0d",
                 sorted_value_o, compare_count_o);
          mismatches++;
        end else begin
          want = sorted_q.pop_front();
          sorted_checked++;
          if (compare_count_o > peak_count) peak_count = 32'(compare_count_o);
          if (sorted_value_o !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, sorted_value_o);
            mismatches++;
          end
          if (compare_count_o !== want.count) begin
            $error("compare_count: expected %0d, got %0d", want.count, compare_count_o);
            mismatches++;
          end
          if (end_of_run_o !== want.eor) begin
            $error("end_of_run: expected %0b, got %0b", want.eor, end_of_run_o);
            mismatches++;
          end
          if (overflowed_o !== want.ovf) begin
            $error("overflowed: expected %0b, got %0b", want.ovf, overflowed_o);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleMax) begin
      $display("stalled for %0d cycles with %0d sorted words outstanding",
               IdleMax, sorted_q.size());
      $display("insertion_sort_with_compare_count_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [DataW-1:0] pick_value(input int unsigned flavor);
    logic signed [DataW-1:0] v;
    case (flavor)
      0: v = $urandom();
      1: begin
        case ($urandom_range(4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = $signed($urandom_range(8)) - 4;
    endcase
    return v;
  endfunction

  task automatic add_word(input logic signed [DataW-1:0] v, input logic last,
                          input bit steady);
    pending_q.push_back('{value: v, last: last, steady: steady});
    words_queued++;
  endtask

  // a run of n words; order 0 random, 1 rising, 2 falling
  task automatic add_run(input int unsigned n, input int unsigned order, input bit steady);
    int unsigned flavor;
    logic signed [DataW-1:0] v;
    flavor = $urandom_range(2);
    v = (order == 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
    for (int unsigned i = 0; i < n; i++) begin
      if (order == 0) v = pick_value(flavor);
      else if (i != 0 && order == 1) v = v + $signed($urandom_range(1 << 24));
      else if (i != 0) v = v - $signed($urandom_range(1, 1 << 24));
      add_word(v, i + 1 == n, steady);
    end
  endtask

  // stimulus and end of run
  initial begin
    int unsigned r;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    value_i      = '0;
    is_final_i   = 1'b0;
    took_word    = 1'b0;
    shadow_fill  = 0;
    shadow_total = 0;
    shadow_ovf   = 1'b0;
    words_queued = 0;
    words_taken  = 0;
    runs_seen    = 0;
    ovf_runs     = 0;
    sorted_checked = 0;
    peak_count   = 0;
    mismatches   = 0;
    idle_cycles  = 0;

    // single-word runs at the value extremes
    add_word(32'sh8000_0000, 1'b1, 1'b0);
    add_word(32'sh7fff_ffff, 1'b1, 1'b0);
    // mixed extremes with repeats
    add_word(32'sh7fff_ffff, 1'b0, 1'b0);
    add_word(32'sh8000_0000, 1'b0, 1'b0);
    add_word(0, 1'b0, 1'b0);
    add_word(-1, 1'b0, 1'b0);
    add_word(1, 1'b0, 1'b0);
    add_word(32'sh8000_0000, 1'b0, 1'b0);
    add_word(32'sh7fff_ffff, 1'b1, 1'b0);
    // all equal words: no inversions
    for (int i = 0; i < 4; i++) add_word(5, i == 3, 1'b0);
    // already ascending, then strictly falling
    add_run(4, 1, 1'b0);
    add_run(5, 2, 1'b0);

    // random runs, with a full falling run for the top count and an overflowing run
    r = 0;
    while (words_queued < 205 || r < 6) begin
      if (r == 2) add_run(Cap, 2, 1'b0);
      else if (r == 5) add_run(Cap + 2, 0, 1'b1);
      else add_run($urandom_range(1, 12), $urandom_range(2), 1'b0);
      r++;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain: every word taken, every sorted word back
    while (words_taken != words_queued || sorted_q.size() != 0) @(negedge clk_i);
    repeat (TailCyc) @(posedge clk_i);

    $display("sent %0d words in %0d runs, %0d runs overflowed the store",
             words_taken, runs_seen, ovf_runs);
    $display("checked %0d sorted words, highest comparison count %0d",
             sorted_checked, peak_count);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("insertion_sort_with_compare_count_tb OK");
    end else begin
      $display("insertion_sort_with_compare_count_tb NOT OK");
    end
    $finish;
  end

endmodule
